@@ src/sgt_pkg.sv @@
// Shared constants and elaboration-time table generators for the sRGB gray converter.
`timescale 1ns / 1ps

package sgt_pkg;

    // Width of the exact integer arithmetic used to build the constant tables.
    localparam int unsigned BIG_W    = 384;
    // Denominator of the sRGB curve after clearing the 0.055 and 1.055 fractions.
    localparam int unsigned SRGB_DEN = 10761;
    // Channel codes at or below this use the linear segment of the sRGB curve.
    localparam int unsigned LIN_KNEE = 10;
    // Number of gray bits, which is also the number of search stages.
    localparam int unsigned GRAY_W   = 8;

    typedef logic [BIG_W-1:0] t_big;
    typedef logic [31:0]      t_word;

    // Multiplies b by base, e times.
    function automatic t_big big_pow(t_big b, t_word base, int unsigned e);
        t_big        r;
        int unsigned i;
        r = b;
        for (i = 0; i < e; i++) begin
            r = r * t_big'(base);
        end
        return r;
    endfunction

    // True when (2k-1)/2^(n+1) <= (a/10761)^(12/5), with both sides raised to the fifth power.
    function automatic logic lin_ok(t_word a, t_word k, int unsigned n);
        t_big l;
        t_big r;
        l = big_pow(t_big'(1), 32'd2 * k - 32'd1, 5);
        l = big_pow(l, t_word'(SRGB_DEN), 12);
        r = big_pow(t_big'(1), a, 12);
        r = r << (5 * (n + 1));
        return (l <= r);
    endfunction

    // Linear light of one 8-bit sRGB code in unsigned Q0.n, rounded to nearest.
    function automatic t_word lin_value(t_word c, int unsigned n);
        t_word       lo;
        t_word       hi;
        t_word       mid;
        t_word       a;
        logic [63:0] num;
        if (c <= t_word'(LIN_KNEE)) begin
            num = ((64'd10 * 64'(c)) << n) + 64'd16473;
            return t_word'(num / 64'd32946);
        end
        a  = 32'd40 * c + 32'd561;
        lo = 32'd0;
        hi = t_word'(1) << n;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 32'd1) >> 1);
            if (lin_ok(a, mid, n)) begin
                lo = mid;
            end else begin
                hi = mid - 32'd1;
            end
        end
        return lo;
    endfunction

    // True when 255 * E(y / 2^n) >= g, where E is the sRGB encoding curve.
    function automatic logic gray_at_least(t_word y, t_word g, int unsigned n);
        logic [63:0] one;
        t_big        l;
        t_big        r;
        one = 64'd1 << n;
        if (64'(y) * 64'd10000000 <= 64'd31308 * one) begin
            return (64'd32946 * 64'(y) >= 64'd10 * 64'(g) * one);
        end
        l = big_pow(t_big'(1), t_word'(SRGB_DEN), 12);
        l = big_pow(l, y, 5);
        r = big_pow(t_big'(1), 32'd40 * g + 32'd561, 12);
        r = r << (5 * n);
        return (l >= r);
    endfunction

    // Smallest luminance in Q0.n whose encoded gray value reaches g.
    function automatic t_word thr_value(t_word g, int unsigned n);
        t_word lo;
        t_word hi;
        t_word mid;
        lo = 32'd0;
        hi = t_word'(1) << n;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (gray_at_least(mid, g, n)) begin
                hi = mid;
            end else begin
                lo = mid + 32'd1;
            end
        end
        return lo;
    endfunction

endpackage

@@ src/srgb_grayscale_threshold.sv @@
// Throughput: one pixel per cycle while the output accepts; three luminance stages,
// eight encoding search stages and the output register each hold one pixel, and a stall
// only fills empty stages.
// Reset (synchronous, active low) empties every stage and loads the register defaults:
// binarize on, threshold 127, low level 0, high level 255. No clearing pass is needed.
`timescale 1ns / 1ps

module srgb_grayscale_threshold #(
    parameter int unsigned LIN_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    // Gray output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] gray_out
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned G_W = sgt_pkg::GRAY_W;

    // Register indexes.
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_THR  = 2'd1;
    localparam logic [1:0] REG_LOW  = 2'd2;
    localparam logic [1:0] REG_HIGH = 2'd3;

    logic           r_mode;
    logic [7:0]     r_thr;
    logic [7:0]     r_low;
    logic [7:0]     r_high;
    logic           w_wr;
    logic [1:0]     w_idx;

    logic           w_luma_valid;
    logic           w_luma_ready;
    logic [LIN_BITS:0] w_luma_y;
    logic           w_enc_valid;
    logic [G_W-1:0] w_enc_gray;
    logic           w_out_adv;
    logic           r_ovld;
    logic [7:0]     r_odata;
    logic [7:0]     n_odata;

    // Register file: a write lands on the access cycle.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_thr  <= 8'd127;
            r_low  <= 8'd0;
            r_high <= 8'd255;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE: r_mode <= pwdata[0];
                REG_THR:  r_thr  <= pwdata[7:0];
                REG_LOW:  r_low  <= pwdata[7:0];
                REG_HIGH: r_high <= pwdata[7:0];
                default:  r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODE: prdata = 32'(r_mode);
            REG_THR:  prdata = 32'(r_thr);
            REG_LOW:  prdata = 32'(r_low);
            REG_HIGH: prdata = 32'(r_high);
            default:  prdata = '0;
        endcase
    end

    // Luminance in linear light.
    sgt_luma #(
        .LIN_BITS (LIN_BITS)
    ) u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_red   (i_s_tdata[7:0]),
        .i_green (i_s_tdata[15:8]),
        .i_blue  (i_s_tdata[23:16]),
        .o_valid (w_luma_valid),
        .i_ready (w_luma_ready),
        .o_y     (w_luma_y)
    );

    // Gamma encoding to an 8-bit gray value.
    sgt_encode #(
        .LIN_BITS (LIN_BITS)
    ) u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_luma_valid),
        .o_ready (w_luma_ready),
        .i_y     (w_luma_y),
        .o_valid (w_enc_valid),
        .i_ready (w_out_adv),
        .o_gray  (w_enc_gray)
    );

    // Output register with the optional binarization.
    assign w_out_adv = !r_ovld || i_m_tready;

    always_comb begin
        if (r_mode) begin
            n_odata = (w_enc_gray < r_thr) ? r_low : r_high;
        end else begin
            n_odata = w_enc_gray;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_adv) begin
            r_ovld <= w_enc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_odata <= n_odata;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_odata;

`ifndef ASSERT_OFF
    a_reset_defaults: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_mode == 1'b1 && r_thr == 8'd127 && r_low == 8'd0
                      && r_high == 8'd255))
        else $error("registers did not take their reset values");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_thr_write: assert property (@(posedge i_clk)
        (i_rst_n && w_wr && (w_idx == REG_THR)) |=> (r_thr == $past(pwdata[7:0])))
        else $error("threshold register missed a write transfer");
`endif

endmodule

@@ src/sgt_luma.sv @@
// Luminance pipeline: sRGB linearization tables, weighted products and rounded sum.
`timescale 1ns / 1ps

module sgt_luma #(
    parameter int unsigned LIN_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [LIN_BITS:0]   o_y
);

    localparam int unsigned Y_W    = LIN_BITS + 1;
    localparam int unsigned PROD_W = 2 * LIN_BITS + 1;
    localparam int unsigned SUM_W  = 2 * LIN_BITS + 3;
    localparam int unsigned YQ_W   = SUM_W - LIN_BITS;

    localparam logic [63:0] ONE64 = 64'd1 << LIN_BITS;
    localparam logic [LIN_BITS-1:0] W_R =
        LIN_BITS'((64'd2126 * ONE64 + 64'd5000) / 64'd10000);
    localparam logic [LIN_BITS-1:0] W_G =
        LIN_BITS'((64'd7152 * ONE64 + 64'd5000) / 64'd10000);
    localparam logic [LIN_BITS-1:0] W_B =
        LIN_BITS'((64'd722 * ONE64 + 64'd5000) / 64'd10000);
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (LIN_BITS - 1);
    localparam logic [YQ_W-1:0]  Y_ONE_Q = YQ_W'(1) << LIN_BITS;
    localparam logic [Y_W-1:0]   Y_ONE   = Y_W'(1) << LIN_BITS;

    // Linearization table, one entry per 8-bit channel code.
    logic [Y_W-1:0] w_lin [256];

    for (genvar c = 0; c < 256; c++) begin : g_lin
        localparam logic [Y_W-1:0] LV = Y_W'(sgt_pkg::lin_value(32'(c), LIN_BITS));
        assign w_lin[c] = LV;
    end

    logic [2:0]        r_vld;
    logic [2:0]        w_adv;
    logic [Y_W-1:0]    r_lin_r;
    logic [Y_W-1:0]    r_lin_g;
    logic [Y_W-1:0]    r_lin_b;
    logic [PROD_W-1:0] r_prod_r;
    logic [PROD_W-1:0] r_prod_g;
    logic [PROD_W-1:0] r_prod_b;
    logic [Y_W-1:0]    r_y;
    logic [SUM_W-1:0]  w_sum;
    logic [YQ_W-1:0]   w_yq;
    logic [Y_W-1:0]    n_y;

    // A stage loads when it is empty or when the stage after it moves on.
    assign w_adv[2] = !r_vld[2] || i_ready;
    assign w_adv[1] = !r_vld[1] || w_adv[2];
    assign w_adv[0] = !r_vld[0] || w_adv[1];
    assign o_ready  = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_adv[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_adv[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    // Stage one: table lookup of the three channels.
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_lin_r <= w_lin[i_red];
            r_lin_g <= w_lin[i_green];
            r_lin_b <= w_lin[i_blue];
        end
    end

    // Stage two: one weight multiplication per channel.
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_prod_r <= PROD_W'(W_R) * PROD_W'(r_lin_r);
            r_prod_g <= PROD_W'(W_G) * PROD_W'(r_lin_g);
            r_prod_b <= PROD_W'(W_B) * PROD_W'(r_lin_b);
        end
    end

    // Stage three: sum, round to Q0.LIN_BITS and saturate at one.
    always_comb begin
        w_sum = SUM_W'(r_prod_r) + SUM_W'(r_prod_g) + SUM_W'(r_prod_b) + HALF;
        w_yq  = w_sum[SUM_W-1:LIN_BITS];
        n_y   = (w_yq > Y_ONE_Q) ? Y_ONE : w_yq[Y_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_y <= n_y;
        end
    end

    assign o_valid = r_vld[2];
    assign o_y     = r_y;

`ifndef ASSERT_OFF
    a_y_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_y <= Y_ONE))
        else $error("luminance above one left the sum stage");
`endif

endmodule

@@ src/sgt_encode.sv @@
// sRGB encoding pipeline: binary search of the gray value over constant luminance thresholds.
`timescale 1ns / 1ps

module sgt_encode #(
    parameter int unsigned LIN_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [LIN_BITS:0]             i_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sgt_pkg::GRAY_W-1:0]    o_gray
);

    localparam int unsigned Y_W    = LIN_BITS + 1;
    localparam int unsigned G_W    = sgt_pkg::GRAY_W;
    localparam int unsigned G_N    = 1 << G_W;
    localparam logic [Y_W-1:0] Y_ONE = Y_W'(1) << LIN_BITS;

    // Threshold table: entry g is the least luminance that encodes to gray g or more.
    logic [Y_W-1:0] w_thr [G_N];

    for (genvar g = 0; g < G_N; g++) begin : g_thr
        localparam logic [Y_W-1:0] TV = Y_W'(sgt_pkg::thr_value(32'(g), LIN_BITS));
        assign w_thr[g] = TV;
    end

    logic [G_W-1:0] r_vld;
    logic [G_W-1:0] w_adv;
    logic [G_W-1:0] r_acc [G_W];
    logic [Y_W-1:0] r_y   [G_W];

    assign o_ready = w_adv[0];

    // One stage per gray bit, most significant first.
    for (genvar k = 0; k < G_W; k++) begin : g_stage
        localparam logic [G_W-1:0] BIT = G_W'(1) << (G_W - 1 - k);

        logic           w_vld_in;
        logic [G_W-1:0] w_acc_in;
        logic [Y_W-1:0] w_y_in;
        logic [G_W-1:0] w_cand;
        logic           w_hit;

        if (k == 0) begin : g_first
            assign w_vld_in = i_valid;
            assign w_acc_in = '0;
            assign w_y_in   = i_y;
        end else begin : g_next
            assign w_vld_in = r_vld[k-1];
            assign w_acc_in = r_acc[k-1];
            assign w_y_in   = r_y[k-1];
        end

        if (k == G_W - 1) begin : g_last_adv
            assign w_adv[k] = !r_vld[k] || i_ready;
        end else begin : g_mid_adv
            assign w_adv[k] = !r_vld[k] || w_adv[k+1];
        end

        // Keep the candidate bit when the luminance reaches its threshold.
        assign w_cand = w_acc_in | BIT;
        assign w_hit  = (w_y_in >= w_thr[w_cand]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k]) begin
                r_acc[k] <= w_hit ? w_cand : w_acc_in;
                r_y[k]   <= w_y_in;
            end
        end
    end

    assign o_valid = r_vld[G_W-1];
    assign o_gray  = r_acc[G_W-1];

`ifndef ASSERT_OFF
    a_full_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[G_W-1] && (r_y[G_W-1] == Y_ONE)) |-> (r_acc[G_W-1] == '1))
        else $error("full luminance did not encode to the top gray value");

    a_full_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[G_W-1] && (r_y[G_W-1] == '0)) |-> (r_acc[G_W-1] == '0))
        else $error("zero luminance did not encode to gray zero");
`endif

endmodule
